### rtl/rhc_pkg.sv
// Shared types for the RGB to HSV converter.
`timescale 1ns / 1ps

package rhc_pkg;

    // Hue sector, chosen by the first maximal channel in the order red, green, blue.
    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // Special-case flags that travel down the pipeline beside the dividers.
    typedef struct packed {
        logic sat_zero;
        logic sat_full;
        logic hue_zero;
    } pix_flags_t;

endpackage

### rtl/rhc_divider.sv
// Pipelined restoring divider for a fraction numer/denom, one quotient bit per stage.
`timescale 1ns / 1ps

module rhc_divider #(
    parameter int DIV_BITS = 8,
    parameter int QUO_BITS = 16,
    parameter int TAG_BITS = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                in_valid,
    input  logic [DIV_BITS-1:0] numer,
    input  logic [DIV_BITS-1:0] denom,
    input  logic [TAG_BITS-1:0] tag,
    output logic                out_valid,
    output logic [QUO_BITS-1:0] quotient,
    output logic [TAG_BITS-1:0] out_tag
);

    // Stage inputs, taken from the ports for the first stage and from the
    // previous stage's registers for the rest.
    logic                valid_in [QUO_BITS];
    logic [DIV_BITS-1:0] rem_in   [QUO_BITS];
    logic [DIV_BITS-1:0] den_in   [QUO_BITS];
    logic [QUO_BITS-1:0] quo_in   [QUO_BITS];
    logic [TAG_BITS-1:0] tag_in   [QUO_BITS];

    // Stage registers. The last stage keeps no remainder or divisor.
    logic                valid_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg   [QUO_BITS];
    logic [TAG_BITS-1:0] tag_reg   [QUO_BITS];
    logic [DIV_BITS-1:0] rem_reg   [QUO_BITS-1];
    logic [DIV_BITS-1:0] den_reg   [QUO_BITS-1];

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : gen_stage
        logic [DIV_BITS:0]   shifted;
        logic                take;
        logic [QUO_BITS-1:0] quo_next;

        // Stage input selection.
        if (k == 0)
        begin : gen_first
            assign valid_in[k] = in_valid;
            assign rem_in[k]   = numer;
            assign den_in[k]   = denom;
            assign quo_in[k]   = '0;
            assign tag_in[k]   = tag;
        end
        else
        begin : gen_next
            assign valid_in[k] = valid_reg[k-1];
            assign rem_in[k]   = rem_reg[k-1];
            assign den_in[k]   = den_reg[k-1];
            assign quo_in[k]   = quo_reg[k-1];
            assign tag_in[k]   = tag_reg[k-1];
        end

        // Double the partial remainder and try to subtract the divisor.
        always_comb
        begin
            shifted  = {rem_in[k], 1'b0};
            take     = (shifted >= {1'b0, den_in[k]});
            quo_next = {quo_in[k][QUO_BITS-2:0], take};
        end

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (enable)
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        // Quotient and tag of this stage.
        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                quo_reg[k] <= quo_next;
                tag_reg[k] <= tag_in[k];
            end
        end

        // Remainder and divisor carried to the next stage.
        if (k < QUO_BITS - 1)
        begin : gen_carry
            logic [DIV_BITS:0]   diff;
            logic [DIV_BITS-1:0] rem_next;

            assign diff     = shifted - {1'b0, den_in[k]};
            assign rem_next = take ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];

            always_ff @(posedge clk)
            begin
                if (enable)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in[k];
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_BITS-1];
    assign quotient  = quo_reg[QUO_BITS-1];
    assign out_tag   = tag_reg[QUO_BITS-1];

endmodule

### rtl/rgb_to_hsv_convert.sv
// Top level of the pipelined RGB to HSV pixel converter.
`timescale 1ns / 1ps

// Converts a stream of RGB pixels to hue, saturation and value.
// Input channel s_axis: one pixel per transaction, red, green and blue packed
// in tdata. Output channel m_axis: one HSV result per transaction, hue,
// saturation and value packed in tdata. Hue is a fraction of a full turn,
// saturation is (max-min)/max saturated to all ones, value is the largest
// channel.
// Throughput: one pixel per cycle while the output register is empty or being
// taken. The pipeline is made of the two restoring dividers, which produce
// one quotient bit per pipeline stage, plus four front stages for the input
// register, max/min, delta and the hue numerator, and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls, every stage holds and s_axis_tready
// drops, so nothing is lost or repeated. Bubbles are carried as cleared valid
// bits. Reset clears all valid bits; the block keeps no other state.
module rgb_to_hsv_convert
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16,
    localparam int IN_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * FRACTION_BITS + CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // red, green, blue; zero padding above
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // hue, saturation, value; zero padding above
);

    localparam int TURN_BITS = CHANNEL_BITS + 3;
    localparam int DIFF_BITS = CHANNEL_BITS + 1;
    localparam int NUM_BITS  = CHANNEL_BITS + 4;
    localparam int SAT_TAG   = CHANNEL_BITS + 2;

    logic advance;

    // Stage 1: input register.
    logic                    stg1_valid_reg;
    logic [CHANNEL_BITS-1:0] stg1_red_reg;
    logic [CHANNEL_BITS-1:0] stg1_green_reg;
    logic [CHANNEL_BITS-1:0] stg1_blue_reg;

    // Stage 2: max, min, sector and channel difference.
    logic                        stg2_valid_reg;
    logic [CHANNEL_BITS-1:0]     stg2_max_reg;
    logic [CHANNEL_BITS-1:0]     stg2_min_reg;
    sector_t                     stg2_sector_reg;
    logic signed [DIFF_BITS-1:0] stg2_diff_reg;
    logic [CHANNEL_BITS-1:0]     max_next;
    logic [CHANNEL_BITS-1:0]     min_next;
    logic [CHANNEL_BITS-1:0]     min_rg;
    sector_t                     sector_next;
    logic signed [DIFF_BITS-1:0] diff_next;

    // Stage 3: delta.
    logic                        stg3_valid_reg;
    logic [CHANNEL_BITS-1:0]     stg3_max_reg;
    logic [CHANNEL_BITS-1:0]     stg3_delta_reg;
    sector_t                     stg3_sector_reg;
    logic signed [DIFF_BITS-1:0] stg3_diff_reg;

    // Stage 4: hue numerator wrapped into one turn, and special-case flags.
    logic                       stg4_valid_reg;
    logic [CHANNEL_BITS-1:0]    stg4_max_reg;
    logic [CHANNEL_BITS-1:0]    stg4_delta_reg;
    logic [TURN_BITS-1:0]       stg4_numer_reg;
    logic [TURN_BITS-1:0]       stg4_turn_reg;
    pix_flags_t                 stg4_flags_reg;
    logic [TURN_BITS-1:0]       turn_next;
    logic [TURN_BITS-1:0]       base_next;
    logic signed [NUM_BITS-1:0] num_raw;
    logic signed [NUM_BITS-1:0] num_wrap;
    pix_flags_t                 flags_next;

    // Divider outputs.
    logic                     sat_div_valid;
    logic [FRACTION_BITS-1:0] sat_quo;
    logic [SAT_TAG-1:0]       sat_tag_out;
    logic                     hue_div_valid;
    logic [FRACTION_BITS-1:0] hue_quo;
    logic                     hue_zero_out;
    logic [CHANNEL_BITS-1:0]  div_max;
    logic                     div_sat_zero;
    logic                     div_sat_full;

    // Output register.
    logic                     out_valid_reg;
    logic [FRACTION_BITS-1:0] out_hue_reg;
    logic [FRACTION_BITS-1:0] out_sat_reg;
    logic [CHANNEL_BITS-1:0]  out_value_reg;
    logic [FRACTION_BITS-1:0] hue_next;
    logic [FRACTION_BITS-1:0] sat_next;

    // All stages move together while the output register can take a result.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Valid bits of the front stages and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg1_valid_reg <= 1'b0;
            stg2_valid_reg <= 1'b0;
            stg3_valid_reg <= 1'b0;
            stg4_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            stg1_valid_reg <= s_axis_tvalid;
            stg2_valid_reg <= stg1_valid_reg;
            stg3_valid_reg <= stg2_valid_reg;
            stg4_valid_reg <= stg3_valid_reg;
            out_valid_reg  <= sat_div_valid && hue_div_valid;
        end
    end

    // Stage 2 logic: the first maximal channel picks the sector.
    always_comb
    begin
        if ((stg1_red_reg >= stg1_green_reg) && (stg1_red_reg >= stg1_blue_reg))
        begin
            sector_next = SECTOR_RED;
            max_next    = stg1_red_reg;
        end
        else if (stg1_green_reg >= stg1_blue_reg)
        begin
            sector_next = SECTOR_GREEN;
            max_next    = stg1_green_reg;
        end
        else
        begin
            sector_next = SECTOR_BLUE;
            max_next    = stg1_blue_reg;
        end

        min_rg   = (stg1_green_reg < stg1_red_reg) ? stg1_green_reg : stg1_red_reg;
        min_next = (stg1_blue_reg < min_rg) ? stg1_blue_reg : min_rg;

        case (sector_next)
            SECTOR_RED:
            begin
                diff_next = $signed({1'b0, stg1_green_reg}) - $signed({1'b0, stg1_blue_reg});
            end
            SECTOR_GREEN:
            begin
                diff_next = $signed({1'b0, stg1_blue_reg}) - $signed({1'b0, stg1_red_reg});
            end
            SECTOR_BLUE:
            begin
                diff_next = $signed({1'b0, stg1_red_reg}) - $signed({1'b0, stg1_green_reg});
            end
            default:
            begin
                diff_next = '0;
            end
        endcase
    end

    // Stage 4 logic: numerator base*delta + diff, wrapped by one turn if negative.
    always_comb
    begin
        turn_next = TURN_BITS'({stg3_delta_reg, 2'b00}) + TURN_BITS'({stg3_delta_reg, 1'b0});

        case (stg3_sector_reg)
            SECTOR_RED:
            begin
                base_next = '0;
            end
            SECTOR_GREEN:
            begin
                base_next = TURN_BITS'({stg3_delta_reg, 1'b0});
            end
            SECTOR_BLUE:
            begin
                base_next = TURN_BITS'({stg3_delta_reg, 2'b00});
            end
            default:
            begin
                base_next = '0;
            end
        endcase

        num_raw  = $signed({1'b0, base_next}) + NUM_BITS'(stg3_diff_reg);
        num_wrap = num_raw[NUM_BITS-1] ? (num_raw + $signed({1'b0, turn_next})) : num_raw;

        flags_next.hue_zero = (stg3_delta_reg == '0);
        flags_next.sat_zero = (stg3_max_reg == '0);
        flags_next.sat_full = (stg3_delta_reg == stg3_max_reg);
    end

    // Front stage payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg1_red_reg    <= s_axis_tdata[CHANNEL_BITS-1:0];
            stg1_green_reg  <= s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
            stg1_blue_reg   <= s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

            stg2_max_reg    <= max_next;
            stg2_min_reg    <= min_next;
            stg2_sector_reg <= sector_next;
            stg2_diff_reg   <= diff_next;

            stg3_max_reg    <= stg2_max_reg;
            stg3_delta_reg  <= stg2_max_reg - stg2_min_reg;
            stg3_sector_reg <= stg2_sector_reg;
            stg3_diff_reg   <= stg2_diff_reg;

            stg4_max_reg    <= stg3_max_reg;
            stg4_delta_reg  <= stg3_delta_reg;
            stg4_numer_reg  <= num_wrap[TURN_BITS-1:0];
            stg4_turn_reg   <= turn_next;
            stg4_flags_reg  <= flags_next;
        end
    end

    // Saturation divider: delta / max, with max and its flags riding along.
    rhc_divider #(
        .DIV_BITS (CHANNEL_BITS),
        .QUO_BITS (FRACTION_BITS),
        .TAG_BITS (SAT_TAG)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .in_valid  (stg4_valid_reg),
        .numer     (stg4_delta_reg),
        .denom     (stg4_max_reg),
        .tag       ({stg4_max_reg, stg4_flags_reg.sat_zero, stg4_flags_reg.sat_full}),
        .out_valid (sat_div_valid),
        .quotient  (sat_quo),
        .out_tag   (sat_tag_out)
    );

    // Hue divider: wrapped numerator over one turn (six times delta).
    rhc_divider #(
        .DIV_BITS (TURN_BITS),
        .QUO_BITS (FRACTION_BITS),
        .TAG_BITS (1)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .in_valid  (stg4_valid_reg),
        .numer     (stg4_numer_reg),
        .denom     (stg4_turn_reg),
        .tag       (stg4_flags_reg.hue_zero),
        .out_valid (hue_div_valid),
        .quotient  (hue_quo),
        .out_tag   (hue_zero_out)
    );

    // Special cases: black and grey pixels, and a saturation of exactly one.
    always_comb
    begin
        div_max      = sat_tag_out[SAT_TAG-1:2];
        div_sat_zero = sat_tag_out[1];
        div_sat_full = sat_tag_out[0];

        hue_next = hue_zero_out ? '0 : hue_quo;

        if (div_sat_zero)
        begin
            sat_next = '0;
        end
        else if (div_sat_full)
        begin
            sat_next = '1;
        end
        else
        begin
            sat_next = sat_quo;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hue_reg   <= hue_next;
            out_sat_reg   <= sat_next;
            out_value_reg <= div_max;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_value_reg, out_sat_reg, out_hue_reg});

endmodule

### tb/testbench.sv
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

module testbench;

    import rhc_pkg::*;

    localparam int CH_BITS   = 8;
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = ((3 * CH_BITS + 7) / 8) * 8;
    localparam int OUT_W     = ((2 * FRAC_BITS + CH_BITS + 7) / 8) * 8;

    // Pipeline depth as given for the block, used for the final settle time.
    localparam int PIPE_LATENCY     = FRAC_BITS + 5;
    localparam int RANDOM_PIXELS    = 1000;
    localparam int MAX_GAP          = 13;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT       = 5000;
    localparam int PRINT_LIMIT      = 100;

    typedef struct packed {
        logic [FRAC_BITS-1:0] hue;
        logic [FRAC_BITS-1:0] saturation;
        logic [CH_BITS-1:0]   value;
    } hsv_t;

    typedef struct {
        logic [IN_W-1:0] pixel;
        int unsigned     gap;
        bit              drain_first;
    } pixel_item_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    pixel_item_t pixel_queue[$];
    hsv_t        hsv_expected[$];
    int unsigned gap_count;
    int unsigned ready_wait;
    int unsigned hold_left;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;

    rgb_to_hsv_convert #(
        .CHANNEL_BITS  (CH_BITS),
        .FRACTION_BITS (FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Expected hue, saturation and value of one pixel, in exact integer arithmetic.
    function automatic hsv_t rgb_to_hsv(logic [IN_W-1:0] pixel);
        logic [CH_BITS-1:0] r;
        logic [CH_BITS-1:0] g;
        logic [CH_BITS-1:0] b;
        logic [CH_BITS-1:0] mx;
        logic [CH_BITS-1:0] mn;
        logic [63:0]        delta;
        logic [63:0]        turn;
        logic [63:0]        num;
        logic [63:0]        quot;
        hsv_t               res;
        r = pixel[CH_BITS-1:0];
        g = pixel[2*CH_BITS-1:CH_BITS];
        b = pixel[3*CH_BITS-1:2*CH_BITS];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = 64'(mx) - 64'(mn);
        res.value = mx;

        // A black pixel has no saturation; a pure ratio of one clips to all ones.
        if (mx == 0) begin
            res.saturation = '0;
        end
        else begin
            quot = (delta << FRAC_BITS) / 64'(mx);
            if (quot > {FRAC_BITS{1'b1}})
                res.saturation = {FRAC_BITS{1'b1}};
            else
                res.saturation = quot[FRAC_BITS-1:0];
        end

        // Grey pixels get hue zero; otherwise the first maximal channel picks
        // the sector, and one turn is added up front so the numerator stays positive.
        if (delta == 0) begin
            res.hue = '0;
        end
        else begin
            turn = 64'd6 * delta;
            if (r == mx)
                num = turn + 64'(g) - 64'(b);
            else if (g == mx)
                num = turn + 64'd2 * delta + 64'(b) - 64'(r);
            else
                num = turn + 64'd4 * delta + 64'(r) - 64'(g);
            if (num >= turn) num = num - turn;
            quot = (num << FRAC_BITS) / turn;
            res.hue = quot[FRAC_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_rgb(int unsigned r, int unsigned g,
                                                 int unsigned b);
        logic [IN_W-1:0] pixel;
        pixel = '0;
        pixel[CH_BITS-1:0]           = CH_BITS'(r);
        pixel[2*CH_BITS-1:CH_BITS]   = CH_BITS'(g);
        pixel[3*CH_BITS-1:2*CH_BITS] = CH_BITS'(b);
        return pixel;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("tb: %0t mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
    endtask

    // Compares one output transaction with the oldest expected result.
    task automatic check_hsv(logic [OUT_W-1:0] data);
        hsv_t got;
        hsv_t want;
        got.hue        = data[FRAC_BITS-1:0];
        got.saturation = data[2*FRAC_BITS-1:FRAC_BITS];
        got.value      = data[2*FRAC_BITS+CH_BITS-1:2*FRAC_BITS];
        if (hsv_expected.size() == 0) begin
            report_mismatch("unexpected result", 64'd0, 64'(data));
        end
        else begin
            want = hsv_expected.pop_front();
            if (got.hue != want.hue)
                report_mismatch("hue", 64'(want.hue), 64'(got.hue));
            if (got.saturation != want.saturation)
                report_mismatch("saturation", 64'(want.saturation), 64'(got.saturation));
            if (got.value != want.value)
                report_mismatch("value", 64'(want.value), 64'(got.value));
        end
    endtask

    // Input driver: offers queued pixels after their gap and records what is accepted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_count     <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                hsv_expected.push_back(rgb_to_hsv(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (gap_count < pixel_queue[0].gap) begin
                    gap_count     <= gap_count + 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_queue[0].drain_first && hsv_expected.size() != 0) begin
                    // Pause until the pipeline has delivered everything.
                    s_axis_tvalid <= 1'b0;
                end
                else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_queue[0].pixel;
                    pixel_queue.delete(0);
                    gap_count     <= 0;
                end
            end
        end
    end

    // Output monitor: checks each transaction and throttles tready.
    always @(posedge clk or negedge rst_n) begin : monitor_proc
        int unsigned stall;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            ready_wait    <= 0;
            hold_left     <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_hsv(m_axis_tdata);
                results_seen++;
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (m_axis_tvalid && m_axis_tready) begin
                if (results_seen == LONG_HOLD_AT) begin
                    // Long back-pressure so the pipeline fills and stalls its input.
                    hold_left     <= LONG_HOLD_CYCLES;
                    m_axis_tready <= 1'b0;
                end
                else begin
                    stall = ((results_seen / 96) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
                    if (stall == 0) begin
                        m_axis_tready <= 1'b1;
                    end
                    else begin
                        m_axis_tready <= 1'b0;
                        ready_wait    <= stall - 1;
                    end
                end
            end
            else if (ready_wait != 0) begin
                ready_wait    <= ready_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction on either side.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        pixel_item_t item;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned kind;

        // Directed pixels: black, white, grey, primaries, ties for the maximum,
        // negative hue that wraps, full saturation and small deltas.
        item.drain_first = 1'b0;
        item.gap = 0;
        item.pixel = pack_rgb(0, 0, 0);       pixel_queue.push_back(item);
        item.pixel = pack_rgb(255, 255, 255); pixel_queue.push_back(item);
        item.pixel = pack_rgb(128, 128, 128); pixel_queue.push_back(item);
        item.pixel = pack_rgb(255, 0, 0);     pixel_queue.push_back(item);
        item.pixel = pack_rgb(0, 255, 0);     pixel_queue.push_back(item);
        item.pixel = pack_rgb(0, 0, 255);     pixel_queue.push_back(item);
        item.gap = 3;
        item.pixel = pack_rgb(255, 255, 0);   pixel_queue.push_back(item);
        item.pixel = pack_rgb(0, 255, 255);   pixel_queue.push_back(item);
        item.pixel = pack_rgb(255, 0, 255);   pixel_queue.push_back(item);
        item.pixel = pack_rgb(255, 0, 1);     pixel_queue.push_back(item);
        item.pixel = pack_rgb(255, 1, 0);     pixel_queue.push_back(item);
        item.gap = 1;
        item.pixel = pack_rgb(1, 0, 0);       pixel_queue.push_back(item);
        item.pixel = pack_rgb(0, 1, 0);       pixel_queue.push_back(item);
        item.pixel = pack_rgb(0, 0, 1);       pixel_queue.push_back(item);
        item.pixel = pack_rgb(1, 1, 0);       pixel_queue.push_back(item);
        item.pixel = pack_rgb(200, 0, 100);   pixel_queue.push_back(item);
        item.gap = 0;
        item.pixel = pack_rgb(255, 254, 253); pixel_queue.push_back(item);
        item.pixel = pack_rgb(254, 255, 253); pixel_queue.push_back(item);
        item.pixel = pack_rgb(253, 254, 255); pixel_queue.push_back(item);
        item.pixel = pack_rgb(1, 2, 3);       pixel_queue.push_back(item);
        item.pixel = pack_rgb(128, 64, 200);  pixel_queue.push_back(item);
        item.pixel = pack_rgb(3, 255, 0);     pixel_queue.push_back(item);
        item.pixel = pack_rgb(170, 85, 255);  pixel_queue.push_back(item);

        // Random pixels, biased toward grey, ties, zero channels and tiny values.
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            kind = $urandom_range(0, 11);
            case (kind)
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    g = r;
                    if (b > r) b = r;
                end
                2: begin
                    b = g;
                    if (r > g) r = g;
                end
                3: begin
                    b = r;
                    if (g > r) g = r;
                end
                4: begin
                    case ($urandom_range(0, 2))
                        0: r = 0;
                        1: g = 0;
                        default: b = 0;
                    endcase
                end
                5: begin
                    r = r % 4;
                    g = g % 4;
                    b = b % 4;
                end
                default: ;
            endcase
            item.pixel = pack_rgb(r, g, b);
            item.gap = ((i / 128) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            item.drain_first = (i % 250 == 249);
            pixel_queue.push_back(item);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (hsv_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);

        if (hsv_expected.size() != 0)
            report_mismatch("results never delivered", 64'(hsv_expected.size()), 64'd0);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/rhc_pkg.sv
rtl/rhc_divider.sv
rtl/rgb_to_hsv_convert.sv
tb/testbench.sv
